[rtl/trimmed_fnv1a64_identity_hash_assert.svh]
// Assertion macros for the trimmed FNV-1a identity hash.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef TRIMMED_FNV1A64_IDENTITY_HASH_ASSERT_SVH
`define TRIMMED_FNV1A64_IDENTITY_HASH_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define TFNV_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication.
`define TFNV_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define TFNV_ASSERT_IMP(lbl, ante, cons, msg)
`define TFNV_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

[rtl/tfnv_pkg.sv]
package tfnv_pkg;

	localparam int ID_W = 63;

	localparam logic [63:0]     FNV_OFFSET  = 64'h1465_0FB0_739D_0383;
	localparam logic [ID_W-1:0] SENTINEL_ID = ID_W'(999);
	localparam logic [ID_W-1:0] SAFE_ID     = ID_W'(1);
	localparam logic [7:0]      SPACE_LIMIT = 8'h20;

	// One input item
	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       last;
	} item_t;

	// One result item
	typedef struct packed {
		logic [ID_W-1:0] player_id;
		logic            is_empty;
	} result_t;

	// FNV-1a step: xor the byte in, then multiply by the prime 2^40 + 0x1B3.
	// The multiply is a fixed shift-add.
	function automatic logic [63:0] fnv_mix(logic [63:0] h, logic [7:0] b);
		logic [63:0] x;
		x = h ^ {56'd0, b};
		return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
	endfunction

endpackage

[rtl/tfnv_if.sv]
// Input channel: one string byte per item
interface tfnv_in_if import tfnv_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_byte;
	logic       last;

	modport source (output valid, data_byte, has_byte, last, input ready);
	modport sink   (input valid, data_byte, has_byte, last, output ready);
endinterface

// Output channel: one identity hash per string
interface tfnv_out_if import tfnv_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [ID_W-1:0] player_id;
	logic            is_empty;

	modport source (output valid, player_id, is_empty, input ready);
	modport sink   (input valid, player_id, is_empty, output ready);
endinterface

[rtl/trimmed_fnv1a64_identity_hash.sv]
// Trimmed FNV-1a 64-bit identity hash. Send a string one byte per item and
// mark its final item with last; bytes at or below 0x20 are trimmed at both
// ends. One result follows each last item: the 63-bit hash (0 and 999 map to
// 1), or 0 with is_empty set for an empty or all-whitespace string. An item
// with has_byte low carries no byte and may end an empty string. The block
// takes one item per cycle; that rate is set by the hash state loop, which
// does the xor and the shift-add multiply by the FNV prime combinationally. A
// result passes the input register and then the output register after its
// last item is accepted, and the input stalls only while a finished result
// waits on the output.
`include "trimmed_fnv1a64_identity_hash_assert.svh"

module trimmed_fnv1a64_identity_hash import tfnv_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	tfnv_in_if.sink           in_ch,
	tfnv_out_if.source        out_ch
);

	item_t   item_s1;
	logic    vld_s1;
	logic    out_vld_q;
	result_t res_q;
	result_t res_nx;
	logic    out_free;
	logic    s1_go;

	// Handshake: the stage moves unless a last item meets a full output
	assign out_free    = !out_vld_q || out_ch.ready;
	assign s1_go       = vld_s1 && (!item_s1.last || out_free);
	assign in_ch.ready = !vld_s1 || s1_go;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			vld_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1.data_byte <= in_ch.data_byte;
			item_s1.has_byte  <= in_ch.has_byte;
			item_s1.last      <= in_ch.last;
		end
	end

	tfnv_hash_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_s1),
		.fire   (s1_go),
		.result (res_nx)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s1_go && item_s1.last) begin
			out_vld_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && item_s1.last) begin
			res_q <= res_nx;
		end
	end

	assign out_ch.valid     = out_vld_q;
	assign out_ch.player_id = res_q.player_id;
	assign out_ch.is_empty  = res_q.is_empty;

	`TFNV_ASSERT_IMP(a_empty_zero, out_ch.valid && out_ch.is_empty,
		out_ch.player_id == '0, "empty result with nonzero id")
	`TFNV_ASSERT_IMP(a_id_legal, out_ch.valid && !out_ch.is_empty,
		out_ch.player_id != '0 && out_ch.player_id != SENTINEL_ID, "reserved id on output")
	`TFNV_ASSERT_NXT(a_last_result, s1_go && item_s1.last, out_ch.valid,
		"last item gave no result")

endmodule

[rtl/tfnv_hash_core.sv]
`include "trimmed_fnv1a64_identity_hash_assert.svh"

module tfnv_hash_core import tfnv_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  item_t   item,
	input  logic    fire,
	output result_t result
);

	logic        seen_q;
	logic [63:0] run_q;
	logic [63:0] com_q;

	logic        is_content;
	logic        is_inner_ws;
	logic [63:0] mixed;
	logic [63:0] run_nx;
	logic [63:0] com_nx;
	logic        seen_nx;
	logic [ID_W-1:0] id_raw;

	// Classify the byte and advance the hash
	always_comb begin
		is_content  = item.has_byte && (item.data_byte > SPACE_LIMIT);
		is_inner_ws = item.has_byte && !is_content && seen_q;
		mixed       = fnv_mix(run_q, item.data_byte);
		run_nx      = (is_content || is_inner_ws) ? mixed : run_q;
		com_nx      = is_content ? mixed : com_q;
		seen_nx     = seen_q || is_content;
	end

	// Result from the committed hash, valid when the item is last
	always_comb begin
		id_raw = com_nx[ID_W-1:0];
		if (!seen_nx) begin
			result.player_id = '0;
			result.is_empty  = 1'b1;
		end else if (id_raw == '0 || id_raw == SENTINEL_ID) begin
			result.player_id = SAFE_ID;
			result.is_empty  = 1'b0;
		end else begin
			result.player_id = id_raw;
			result.is_empty  = 1'b0;
		end
	end

	// Hash state; a last item returns it to the start value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
			run_q  <= FNV_OFFSET;
			com_q  <= FNV_OFFSET;
		end else if (fire) begin
			if (item.last) begin
				seen_q <= 1'b0;
				run_q  <= FNV_OFFSET;
				com_q  <= FNV_OFFSET;
			end else begin
				seen_q <= seen_nx;
				run_q  <= run_nx;
				com_q  <= com_nx;
			end
		end
	end

	`TFNV_ASSERT_NXT(a_restart, fire && item.last, !seen_q && run_q == FNV_OFFSET && com_q == FNV_OFFSET, "hash state not restarted after last item")
	`TFNV_ASSERT_NXT(a_nobyte_hold, fire && !item.has_byte && !item.last, run_q == $past(run_q) && com_q == $past(com_q), "item without byte changed the hash")
	`TFNV_ASSERT_IMP(a_commit_seen, seen_q == 1'b0, run_q == FNV_OFFSET, "running hash moved before any content byte")

endmodule

[tb/tb_trimmed_fnv1a64_identity_hash.sv]
`timescale 1ns / 100ps

module tb_trimmed_fnv1a64_identity_hash;
	import tfnv_pkg::*;

	localparam logic [63:0] FNV_PRIME_64 = 64'h0000_0100_0000_01B3;
	localparam int          CYCLE_LIMIT  = 200000;
	localparam int          DRAIN_TAIL   = 5;

	logic clk;
	logic arst_n;

	tfnv_in_if  in_ch ();
	tfnv_out_if out_ch ();

	trimmed_fnv1a64_identity_hash u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// Shadow hash state, tracks the block item by item
	logic        id_seen;
	logic [63:0] id_run_hash;
	logic [63:0] id_commit_hash;
	result_t     pending_ids[$];

	int  bad_ids;
	int  items_sent;
	int  cycle_count;
	int  rx_hold_cycles;
	bit  tx_idle;
	bit  rx_idle;

	// Clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// FNV-1a step as a plain multiply by the prime
	function automatic logic [63:0] fnv_step(logic [63:0] h, logic [7:0] b);
		return (h ^ {56'd0, b}) * FNV_PRIME_64;
	endfunction

	function automatic void id_clear();
		id_seen        = 1'b0;
		id_run_hash    = FNV_OFFSET;
		id_commit_hash = FNV_OFFSET;
	endfunction

	// Fold one accepted item into the shadow state; queue the id on last
	function automatic void hash_take(logic [7:0] b, logic has, logic fin);
		result_t         r;
		logic [ID_W-1:0] id;
		if (has) begin
			if (b > SPACE_LIMIT) begin
				id_run_hash    = fnv_step(id_run_hash, b);
				id_commit_hash = id_run_hash;
				id_seen        = 1'b1;
			end else if (id_seen) begin
				// inner whitespace stays pending until more content shows up
				id_run_hash = fnv_step(id_run_hash, b);
			end
		end
		if (fin) begin
			if (id_seen) begin
				id = id_commit_hash[ID_W-1:0];
				if (id == '0 || id == SENTINEL_ID)
					id = SAFE_ID;
				r.player_id = id;
				r.is_empty  = 1'b0;
			end else begin
				r.player_id = '0;
				r.is_empty  = 1'b1;
			end
			pending_ids.push_back(r);
			id_clear();
		end
	endfunction

	function automatic void note_bad(string what, result_t want, logic [ID_W-1:0] got_id,
			logic got_empty);
		bad_ids++;
		if (bad_ids <= 10)
			$display("%0t %s: want id=%0d empty=%0b, got id=%0d empty=%0b",
				$time, what, want.player_id, want.is_empty, got_id, got_empty);
	endfunction

	// Input side monitor: predict on every accepted item
	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready)
			hash_take(in_ch.data_byte, in_ch.has_byte, in_ch.last);
	end

	// Output side checker
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_ids.size() == 0) begin
				want = '0;
				note_bad("id with none expected", want, out_ch.player_id, out_ch.is_empty);
			end else begin
				want = pending_ids.pop_front();
				if (out_ch.player_id !== want.player_id || out_ch.is_empty !== want.is_empty)
					note_bad("id mismatch", want, out_ch.player_id, out_ch.is_empty);
			end
		end
	end

	// Receiver: random stalls per result, plus a long hold on request
	initial begin
		int stall;
		out_ch.ready = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (rx_hold_cycles > 0) begin
				out_ch.ready <= 1'b0;
				repeat (rx_hold_cycles) @(posedge clk);
				rx_hold_cycles = 0;
			end
			stall = rx_idle ? $urandom_range(0, 3) : 0;
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do
				@(posedge clk);
			while (!out_ch.valid && rx_hold_cycles == 0);
		end
	end

	// Watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("trimmed_fnv1a64_identity_hash: mismatch");
		$finish;
	end

	// Offer one item and hold it until the block takes it
	task automatic send_item(input logic [7:0] b, input logic has, input logic fin);
		int gap;
		gap = tx_idle ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.data_byte <= b;
		in_ch.has_byte  <= has;
		in_ch.last      <= fin;
		do
			@(posedge clk);
		while (!in_ch.ready);
		items_sent++;
	endtask

	// Stop offering and wait until every queued id has come out
	task automatic wait_drain();
		in_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_ids.size() != 0);
		repeat (DRAIN_TAIL) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_space();
		return 8'($urandom_range(0, 32));
	endfunction

	function automatic logic [7:0] pick_content();
		return 8'($urandom_range(33, 255));
	endfunction

	// One string: leading blanks, body with inner blanks, trailing blanks,
	// stray byteless items; last lands on a byte or on a byteless item
	task automatic send_random_string(input int max_body);
		int         lead;
		int         body;
		int         trail;
		int         n;
		bit         end_bare;
		logic [7:0] b;
		lead     = $urandom_range(0, 3);
		body     = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, max_body);
		trail    = $urandom_range(0, 3);
		end_bare = ($urandom_range(0, 3) == 0);
		n        = lead + body + trail;
		if (n == 0)
			end_bare = 1'b1;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_item(8'($urandom), 1'b0, 1'b0);
			if (i < lead || i >= lead + body)
				b = pick_space();
			else if ($urandom_range(0, 3) == 0)
				b = pick_space();
			else
				b = pick_content();
			send_item(b, 1'b1, !end_bare && i == n - 1);
		end
		if (end_bare)
			send_item(8'($urandom), 1'b0, 1'b1);
	endtask

	// Edge cases: empty, all blank, single bytes, trimming, byteless items
	task automatic test_directed();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'h20, 1'b1, 1'b0);
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'h09, 1'b1, 1'b1);
		send_item(8'hFF, 1'b1, 1'b1);
		send_item(8'h21, 1'b1, 1'b1);
		// blank around, zero byte inside
		send_item(8'h20, 1'b1, 1'b0);
		send_item(8'h61, 1'b1, 1'b0);
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'h62, 1'b1, 1'b0);
		send_item(8'h20, 1'b1, 1'b1);
		// byteless items inside and at the end
		send_item(8'h41, 1'b1, 1'b0);
		send_item(8'hAA, 1'b0, 1'b0);
		send_item(8'h42, 1'b1, 1'b0);
		send_item(8'h55, 1'b0, 1'b1);
		// trailing blanks then a byteless last
		send_item(8'h78, 1'b1, 1'b0);
		send_item(8'h20, 1'b1, 1'b0);
		send_item(8'h20, 1'b1, 1'b0);
		send_item(8'hFF, 1'b0, 1'b1);
		send_item(8'h7F, 1'b1, 1'b0);
		send_item(8'h80, 1'b1, 1'b1);
		wait_drain();
	endtask

	// Random strings, idling on both sides switched now and then
	task automatic test_random(input int n_items, input bit idle_on);
		int stop_at;
		stop_at = items_sent + n_items;
		tx_idle = idle_on;
		rx_idle = idle_on;
		while (items_sent < stop_at) begin
			if (idle_on && $urandom_range(0, 15) == 0) begin
				tx_idle = 1'($urandom_range(0, 1));
				rx_idle = 1'($urandom_range(0, 1));
			end
			send_random_string(12);
		end
	endtask

	// Receiver holds off while short strings keep coming, so the input stalls
	task automatic test_output_hold();
		tx_idle        = 1'b0;
		rx_idle        = 1'b0;
		rx_hold_cycles = 300;
		for (int i = 0; i < 60; i++)
			send_random_string(2);
		wait_drain();
	endtask

	// Sender stops after each string until its id is out
	task automatic test_sender_pause();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		for (int i = 0; i < 20; i++) begin
			send_random_string(10);
			wait_drain();
		end
	endtask

	initial begin
		arst_n             = 1'b0;
		in_ch.valid        = 1'b0;
		in_ch.data_byte    = '0;
		in_ch.has_byte     = 1'b0;
		in_ch.last         = 1'b0;
		bad_ids            = 0;
		items_sent         = 0;
		rx_hold_cycles     = 0;
		tx_idle            = 1'b0;
		rx_idle            = 1'b0;
		id_clear();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(700, 1'b1);
		test_random(300, 1'b0);
		test_output_hold();
		test_sender_pause();
		test_random(1650 - items_sent, 1'b1);
		wait_drain();

		if (bad_ids == 0 && pending_ids.size() == 0)
			$display("trimmed_fnv1a64_identity_hash: match");
		else
			$display("trimmed_fnv1a64_identity_hash: mismatch");
		$finish;
	end

endmodule

[trimmed_fnv1a64_identity_hash.f]
+incdir+rtl
rtl/tfnv_pkg.sv
rtl/tfnv_if.sv
rtl/tfnv_hash_core.sv
rtl/trimmed_fnv1a64_identity_hash.sv
tb/tb_trimmed_fnv1a64_identity_hash.sv
